[rtl/core/essa_pkg.sv]
// ----------------------------------------------------------------------------
// essa_pkg: shared types and constants for the sparse synapse accumulator
// Holds field widths, action codes and the command word passed from the
// front end through the command queue to the back end.
// ----------------------------------------------------------------------------
package essa_pkg;

  // Fixed field widths of the channel words
  localparam int ACTION_W = 2;
  localparam int ADDR_W   = 12;
  localparam int ID_W     = 10;
  localparam int RANGE_W  = 13;
  localparam int WEIGHT_W = 32;

  // Table pointer width: holds any table position and the table depth itself
  localparam int PTR_W = 17;

  // Command queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // Reset value of the weight register: 1.0 in Q16.16
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 32'h0001_0000;

  // Action codes on the input channel
  localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_EVENT = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

  // Command kinds kept in the queue
  typedef enum logic [1:0] {
    K_LOAD,
    K_EVENT,
    K_READ
  } essa_kind_e;

  // Operations in the accumulator pipeline
  typedef enum logic {
    OP_ADD,
    OP_READ
  } essa_op_e;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BE_CLEAR,
    BE_RUN,
    BE_WALK
  } essa_state_e;

  // Command word: addr is the load position or the range start,
  // id is the loaded target id or the read target, stop is the clamped end
  typedef struct packed {
    essa_kind_e         kind;
    logic [PTR_W-1:0]   addr;
    logic [ID_W-1:0]    id;
    logic [PTR_W-1:0]   stop;
  } essa_cmd_t;

  // Control bits carried down the accumulator pipeline
  typedef struct packed {
    logic             valid;
    essa_op_e         op;
    logic [ID_W-1:0]  rd_tgt;
  } essa_pipe_t;

endpackage

[rtl/core/essa_if.sv]
// ----------------------------------------------------------------------------
// essa_if: valid/ready channels of the sparse synapse accumulator
// essa_evt_if carries input words, essa_res_if carries result words.
// ----------------------------------------------------------------------------
interface essa_evt_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [11:0] table_address;
  logic [9:0]  target_entry;
  logic        fired;
  logic [12:0] range_start;
  logic [12:0] range_stop;
  logic [9:0]  read_target;

  modport source (
    output valid, action, table_address, target_entry, fired,
           range_start, range_stop, read_target,
    input  ready
  );

  modport sink (
    input  valid, action, table_address, target_entry, fired,
           range_start, range_stop, read_target,
    output ready
  );
endinterface

interface essa_res_if #(
  parameter int SUM_WIDTH = 48
);
  logic                        valid;
  logic                        ready;
  logic [9:0]                  target_id;
  logic signed [SUM_WIDTH-1:0] total;

  modport source (
    output valid, target_id, total,
    input  ready
  );

  modport sink (
    input  valid, target_id, total,
    output ready
  );
endinterface

[rtl/core/essa_front.sv]
// ----------------------------------------------------------------------------
// essa_front: input classifier
// Accepts input words, drops the ones that change nothing and turns the rest
// into queue commands with the range end clamped to the table depth.
// ----------------------------------------------------------------------------
module essa_front
  import essa_pkg::*;
#(
  parameter int TABLE_DEPTH = 4096
) (
  essa_evt_if.sink    evt_i,
  input  logic        busy_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output essa_cmd_t   q_cmd_o
);

  logic             accept;
  logic             keep;
  logic [PTR_W-1:0] start_w;
  logic [PTR_W-1:0] stop_w;
  logic [PTR_W-1:0] depth_w;
  logic [PTR_W-1:0] stop_c;

  // Hold off while the accumulators are being cleared or the queue is full
  assign evt_i.ready = !busy_i && !q_full_i;
  assign accept      = evt_i.valid && evt_i.ready;

  // Clamp the range end to the table
  assign start_w = PTR_W'(evt_i.range_start);
  assign stop_w  = PTR_W'(evt_i.range_stop);
  assign depth_w = PTR_W'(TABLE_DEPTH);
  assign stop_c  = (stop_w > depth_w) ? depth_w : stop_w;

  // Classify the word; drop loads off the table, quiet or empty events and unused actions
  always_comb begin
    keep          = 1'b0;
    q_cmd_o.kind  = K_READ;
    q_cmd_o.addr  = start_w;
    q_cmd_o.id    = evt_i.read_target;
    q_cmd_o.stop  = stop_c;
    case (evt_i.action)
      ACT_LOAD: begin
        q_cmd_o.kind = K_LOAD;
        q_cmd_o.addr = PTR_W'(evt_i.table_address);
        q_cmd_o.id   = evt_i.target_entry;
        keep         = 32'(evt_i.table_address) < 32'(TABLE_DEPTH);
      end
      ACT_EVENT: begin
        q_cmd_o.kind = K_EVENT;
        keep         = evt_i.fired && (start_w < stop_c);
      end
      ACT_READ: begin
        q_cmd_o.kind = K_READ;
        keep         = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign q_push_o = accept && keep;

endmodule

[rtl/core/essa_fifo.sv]
// ----------------------------------------------------------------------------
// essa_fifo: command queue between front end and back end
// A small flop-based queue that lets either side stall on its own.
// ----------------------------------------------------------------------------
module essa_fifo
  import essa_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  essa_cmd_t  push_cmd_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output essa_cmd_t  head_o
);

  essa_cmd_t         mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store pushed words
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

[rtl/core/essa_back.sv]
// ----------------------------------------------------------------------------
// essa_back: table, accumulators and update pipeline
// Runs queued commands: writes the target table, walks event ranges at one
// accumulator update per cycle and serves read-and-clear requests.
// ----------------------------------------------------------------------------
module essa_back
  import essa_pkg::*;
#(
  parameter int TABLE_DEPTH  = 4096,
  parameter int TARGET_COUNT = 1024,
  parameter int SUM_WIDTH    = 48
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [WEIGHT_W-1:0] cfg_wdata_i,
  input  logic                q_valid_i,
  input  essa_cmd_t           q_head_i,
  output logic                q_pop_o,
  output logic                busy_o,
  essa_res_if.source          res_o
);

  localparam int TW = $clog2(TABLE_DEPTH);
  localparam int AW = $clog2(TARGET_COUNT);

  // Memories
  logic [ID_W-1:0]      tbl_mem [TABLE_DEPTH];
  logic [SUM_WIDTH-1:0] acc_mem [TARGET_COUNT];
  logic [ID_W-1:0]      tbl_rdata_q;
  logic [SUM_WIDTH-1:0] acc_rdata_q;

  // Sequencer
  essa_state_e      state_q, state_d;
  logic [PTR_W-1:0] j_q, j_d;
  logic [PTR_W-1:0] stop_q, stop_d;
  logic [AW-1:0]    clr_cnt_q, clr_cnt_d;
  logic [WEIGHT_W-1:0] weight_q;

  // Issue
  logic             iss_valid;
  essa_op_e         iss_op;
  logic [PTR_W-1:0] iss_taddr;
  logic [ID_W-1:0]  iss_tgt;
  logic             tbl_we;
  logic             read_busy;
  logic             clearing;

  // Pipeline
  essa_pipe_t       p1_q, p2_q;
  logic [ID_W-1:0]  s1_id;
  logic             s1_inr;
  logic [AW-1:0]    s1_addr;
  logic [AW-1:0]    p2_addr_q;
  logic             p2_inr_q;

  // Stage 2 arithmetic and write port
  logic [SUM_WIDTH-1:0] cur;
  logic [SUM_WIDTH:0]   sum_ext;
  logic [SUM_WIDTH-1:0] sat;
  logic                 acc_we;
  logic [AW-1:0]        acc_waddr;
  logic [SUM_WIDTH-1:0] acc_wdata;
  logic                 wr_valid_q;
  logic [AW-1:0]        wr_addr_q;
  logic [SUM_WIDTH-1:0] wr_data_q;

  // Output register
  logic                 out_valid_q;
  logic [ID_W-1:0]      out_tgt_q;
  logic [SUM_WIDTH-1:0] out_total_q;

  assign busy_o = clearing;

  // Weight register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= WEIGHT_RST;
    end else if (cfg_we_i) begin
      weight_q <= cfg_wdata_i;
    end
  end

  assign read_busy = (p1_q.valid && p1_q.op == OP_READ) ||
                     (p2_q.valid && p2_q.op == OP_READ);

  // Next state and issue control
  always_comb begin
    state_d   = state_q;
    j_d       = j_q;
    stop_d    = stop_q;
    clr_cnt_d = clr_cnt_q;
    q_pop_o   = 1'b0;
    tbl_we    = 1'b0;
    iss_valid = 1'b0;
    iss_op    = OP_ADD;
    iss_taddr = j_q;
    iss_tgt   = q_head_i.id;
    clearing  = 1'b0;
    case (state_q)
      BE_CLEAR: begin
        clearing  = 1'b1;
        clr_cnt_d = clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(TARGET_COUNT - 1)) begin
          state_d = BE_RUN;
        end
      end
      BE_RUN: begin
        if (q_valid_i) begin
          case (q_head_i.kind)
            K_LOAD: begin
              q_pop_o = 1'b1;
              tbl_we  = 1'b1;
            end
            K_EVENT: begin
              q_pop_o   = 1'b1;
              iss_valid = 1'b1;
              iss_taddr = q_head_i.addr;
              j_d       = q_head_i.addr + PTR_W'(1);
              stop_d    = q_head_i.stop;
              if (q_head_i.addr + PTR_W'(1) != q_head_i.stop) begin
                state_d = BE_WALK;
              end
            end
            K_READ: begin
              // Launch only when the result slot is sure to be free
              if (!out_valid_q && !read_busy) begin
                q_pop_o   = 1'b1;
                iss_valid = 1'b1;
                iss_op    = OP_READ;
              end
            end
            default: begin
              q_pop_o = 1'b1;
            end
          endcase
        end
      end
      BE_WALK: begin
        iss_valid = 1'b1;
        iss_taddr = j_q;
        j_d       = j_q + PTR_W'(1);
        if (j_q + PTR_W'(1) == stop_q) begin
          state_d = BE_RUN;
        end
      end
      default: begin
        state_d = BE_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BE_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q    <= j_d;
    stop_q <= stop_d;
  end

  // Target table: load writes, walk reads
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[q_head_i.addr[TW-1:0]] <= q_head_i.id;
    end
    tbl_rdata_q <= tbl_mem[iss_taddr[TW-1:0]];
  end

  // Stage 1: pick the accumulator and read it
  assign s1_id   = (p1_q.op == OP_ADD) ? tbl_rdata_q : p1_q.rd_tgt;
  assign s1_inr  = 32'(s1_id) < 32'(TARGET_COUNT);
  assign s1_addr = AW'(s1_id);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q <= '0;
      p2_q <= '0;
    end else begin
      p1_q.valid  <= iss_valid;
      p1_q.op     <= iss_op;
      p1_q.rd_tgt <= iss_tgt;
      p2_q        <= p1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p2_addr_q <= s1_addr;
    p2_inr_q  <= s1_inr;
  end

  // Stage 2: forward last write, saturating add
  assign cur = (wr_valid_q && wr_addr_q == p2_addr_q) ? wr_data_q : acc_rdata_q;

  always_comb begin
    sum_ext = {cur[SUM_WIDTH-1], cur} +
              {{(SUM_WIDTH + 1 - WEIGHT_W){weight_q[WEIGHT_W-1]}}, weight_q};
    if (sum_ext[SUM_WIDTH] != sum_ext[SUM_WIDTH-1]) begin
      sat = sum_ext[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                               : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end else begin
      sat = sum_ext[SUM_WIDTH-1:0];
    end
  end

  // Write port: clearing pass or pipeline write-back
  always_comb begin
    if (clearing) begin
      acc_we    = 1'b1;
      acc_waddr = clr_cnt_q;
      acc_wdata = '0;
    end else begin
      acc_we    = p2_q.valid && p2_inr_q;
      acc_waddr = p2_addr_q;
      acc_wdata = (p2_q.op == OP_ADD) ? sat : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    acc_rdata_q <= acc_mem[s1_addr];
  end

  // Remember the write made at this edge for the next stage-2 word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_valid_q <= 1'b0;
    end else begin
      wr_valid_q <= acc_we;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q <= acc_waddr;
    wr_data_q <= acc_wdata;
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (p2_q.valid && p2_q.op == OP_READ) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p2_q.valid && p2_q.op == OP_READ) begin
      out_tgt_q   <= p2_q.rd_tgt;
      out_total_q <= p2_inr_q ? cur : '0;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.target_id = out_tgt_q;
  assign res_o.total     = out_total_q;

`ifndef SYNTHESIS
  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p2_q.valid && p2_q.op == OP_READ) |-> !out_valid_q)
    else $error("read result would overwrite a pending word");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BE_WALK) |-> (j_q < stop_q))
    else $error("range walk past its end");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> (!q_pop_o && !iss_valid && !p2_q.valid))
    else $error("pipeline active during clearing pass");

  a_issue_flows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iss_valid |=> p1_q.valid)
    else $error("issued update lost before stage 1");
`endif

endmodule

[rtl/core/event_sparse_synapse_accumulate.sv]
// ----------------------------------------------------------------------------
// event_sparse_synapse_accumulate: event-driven sparse synaptic accumulator
// Top level: front classifier, command queue and accumulator back end.
// ----------------------------------------------------------------------------
// After reset the block clears all TARGET_COUNT accumulator entries, one
// entry per cycle, with evt_i.ready low. Once running, a load word writes
// the target table in the back end; a fired event over a range of table
// positions is walked by the back end issuing one accumulator update per
// cycle into a three-stage table-read, accumulator-read, add-and-write
// pipeline; a read word waits until the result register and the pipeline
// hold no other read, then issues and passes through the pipeline stages
// into the result register. Words that change nothing (loads beyond the
// table, quiet or empty events, unused actions) are taken and dropped in
// the front end. A four-entry queue sits between the front and back ends, so
// input words keep flowing while a range walk runs or a result waits on res_o.
// ----------------------------------------------------------------------------
module event_sparse_synapse_accumulate
  import essa_pkg::*;
#(
  parameter int TABLE_DEPTH  = 4096,
  parameter int TARGET_COUNT = 1024,
  parameter int SUM_WIDTH    = 48
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [WEIGHT_W-1:0] cfg_wdata_i,
  essa_evt_if.sink            evt_i,
  essa_res_if.source          res_o
);

  logic      busy;
  logic      q_full;
  logic      q_push;
  essa_cmd_t q_push_cmd;
  logic      q_pop;
  logic      q_valid;
  essa_cmd_t q_head;

  // Classify incoming words
  essa_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .evt_i    (evt_i),
    .busy_i   (busy),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_cmd_o  (q_push_cmd)
  );

  // Decouple front and back
  essa_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  // Run commands against the table and accumulators
  essa_back #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .TARGET_COUNT (TARGET_COUNT),
    .SUM_WIDTH    (SUM_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .busy_o      (busy),
    .res_o       (res_o)
  );

endmodule

[tb/sv/event_sparse_synapse_accumulate_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_sparse_synapse_accumulate_tb: self-checking bench for the accumulator
// Drives load, event and read words with random idle gaps on both channels.
// A scoreboard class keeps its own copy of the target table, the accumulators
// and the weight, predicts every read result and checks each result word.
// Covers table edges, quiet, empty, reversed and clamped ranges, the spare
// action, saturation both ways and a long result stall that backs up input.
// ----------------------------------------------------------------------------
module event_sparse_synapse_accumulate_tb;
  import essa_pkg::*;

  localparam int TABLE_DEPTH  = 4096;
  localparam int TARGET_COUNT = 1024;
  localparam int SUM_WIDTH    = 48;

  localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

  localparam longint SUM_MAX = (64'sd1 <<< (SUM_WIDTH - 1)) - 64'sd1;
  localparam longint SUM_MIN = -SUM_MAX - 64'sd1;

  localparam int RESET_CYCLES       = 7;
  localparam int DRAIN_CYCLES       = 8;
  localparam int END_CYCLES         = 16;
  localparam int TARGET_POOL        = 16;
  localparam int SAT_TARGET         = 1023;
  localparam int SAT_BASE           = 3840;
  localparam int SAT_EVENTS         = 270;
  localparam int RANDOM_PHASE_WORDS = 110;
  localparam int PRESSURE_AT        = 30;
  localparam int PRESSURE_CYCLES    = 300;
  localparam longint LIMIT_NS       = 64'd80_000_000;

  // One input word as driven onto the event channel
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ADDR_W-1:0]   table_address;
    logic [ID_W-1:0]     target_entry;
    logic                fired;
    logic [RANGE_W-1:0]  range_start;
    logic [RANGE_W-1:0]  range_stop;
    logic [ID_W-1:0]     read_target;
  } syn_word_t;

  localparam int WORD_W = $bits(syn_word_t);

  // One expected result word
  typedef struct packed {
    logic [ID_W-1:0]             id;
    logic signed [SUM_WIDTH-1:0] total;
  } tally_t;

  // Predicts accumulator totals and checks result words in order
  class accumulator_scoreboard;
    logic [ID_W-1:0]            target_map [TABLE_DEPTH];
    bit                         loaded [TABLE_DEPTH];
    int                         loaded_list [$];
    longint                     acc_sum [TARGET_COUNT];
    logic signed [WEIGHT_W-1:0] weight_q;
    tally_t                     expected_tallies [$];
    int                         errors;
    int                         checked;

    function new();
      weight_q = WEIGHT_RST;
      foreach (acc_sum[i]) acc_sum[i] = 0;
      foreach (loaded[i]) loaded[i] = 1'b0;
      errors  = 0;
      checked = 0;
    endfunction

    function int pending();
      return expected_tallies.size();
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function longint add_saturated(longint acc, longint step);
      longint s;
      s = acc + step;
      if (s > SUM_MAX) return SUM_MAX;
      if (s < SUM_MIN) return SUM_MIN;
      return s;
    endfunction

    // Apply one accepted word to the predicted state
    task note_word(syn_word_t w);
      int     stop;
      int     tgt;
      longint step;
      tally_t t;
      case (w.action)
        ACT_LOAD: begin
          target_map[w.table_address] = w.target_entry;
          if (!loaded[w.table_address]) begin
            loaded[w.table_address] = 1'b1;
            loaded_list.push_back(int'(w.table_address));
          end
        end
        ACT_EVENT: begin
          if (w.fired) begin
            stop = (int'(w.range_stop) > TABLE_DEPTH) ? TABLE_DEPTH : int'(w.range_stop);
            step = longint'(weight_q);
            for (int j = int'(w.range_start); j < stop; j++) begin
              tgt = int'(target_map[j]);
              if (tgt < TARGET_COUNT) acc_sum[tgt] = add_saturated(acc_sum[tgt], step);
            end
          end
        end
        ACT_READ: begin
          tgt     = int'(w.read_target);
          t.id    = w.read_target;
          t.total = '0;
          if (tgt < TARGET_COUNT) begin
            t.total      = SUM_WIDTH'(acc_sum[tgt]);
            acc_sum[tgt] = 0;
          end
          expected_tallies.push_back(t);
        end
        default: ;
      endcase
    endtask

    // Compare one result word against the oldest expectation
    task check_tally(logic [ID_W-1:0] id, logic signed [SUM_WIDTH-1:0] total);
      tally_t want;
      if (expected_tallies.size() == 0) begin
        report($sformatf("result with nothing pending: id %0d total %0d", id, total));
      end else begin
        want = expected_tallies.pop_front();
        checked++;
        if (id !== want.id)
          report($sformatf("target_id %0d, want %0d", id, want.id));
        if (total !== want.total)
          report($sformatf("total for id %0d is %0d, want %0d", want.id, total, want.total));
      end
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [WEIGHT_W-1:0] cfg_wdata_i;

  essa_evt_if evt ();
  essa_res_if #(.SUM_WIDTH(SUM_WIDTH)) res ();

  accumulator_scoreboard board = new();

  int words_sent      = 0;
  int weights_written = 0;
  int fill_ptr        = 3;
  int src_run         = 0;
  bit src_calm        = 1'b0;
  int snk_run         = 0;
  bit snk_calm        = 1'b0;

  event_sparse_synapse_accumulate #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TARGET_COUNT(TARGET_COUNT),
    .SUM_WIDTH   (SUM_WIDTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .evt_i      (evt),
    .res_o      (res)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Draw an idle gap; runs of calm stretches drop idling entirely
  function automatic int draw_gap(inout int run_left, inout bit calm);
    if (run_left == 0) begin
      calm     = ($urandom_range(0, 3) == 0);
      run_left = $urandom_range(10, 40);
    end
    run_left--;
    return calm ? 0 : int'($urandom_range(0, 4));
  endfunction

  // Word with every field random and the action forced
  function automatic syn_word_t any_word(logic [ACTION_W-1:0] act);
    syn_word_t w;
    w               = WORD_W'({$urandom, $urandom});
    w.action        = act;
    return w;
  endfunction

  function automatic syn_word_t load_word(int addr, int id);
    syn_word_t w;
    w               = any_word(ACT_LOAD);
    w.table_address = ADDR_W'(addr);
    w.target_entry  = ID_W'(id);
    return w;
  endfunction

  function automatic syn_word_t event_word(bit fired, int start, int stop);
    syn_word_t w;
    w             = any_word(ACT_EVENT);
    w.fired       = fired;
    w.range_start = RANGE_W'(start);
    w.range_stop  = RANGE_W'(stop);
    return w;
  endfunction

  function automatic syn_word_t read_word(int id);
    syn_word_t w;
    w             = any_word(ACT_READ);
    w.read_target = ID_W'(id);
    return w;
  endfunction

  // Random word: mostly loads, walks over loaded positions and reads
  function automatic syn_word_t random_word();
    syn_word_t w;
    int        pick;
    int        s;
    int        e;
    int        fan;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      w = any_word(ACT_LOAD);
      if ($urandom_range(0, 1) == 1 && fill_ptr < TABLE_DEPTH) begin
        w.table_address = ADDR_W'(fill_ptr);
        fill_ptr++;
      end
      if ($urandom_range(0, 2) != 0)
        w.target_entry = ID_W'($urandom_range(0, TARGET_POOL - 1));
    end else if (pick < 65) begin
      // walk only over positions that hold a loaded entry
      s   = board.loaded_list[$urandom_range(0, board.loaded_list.size() - 1)];
      fan = $urandom_range(1, 32);
      e   = s + 1;
      while (e < TABLE_DEPTH && e - s < fan && board.loaded[e]) e++;
      if (e == TABLE_DEPTH && $urandom_range(0, 1) == 1) e = $urandom_range(TABLE_DEPTH, 8191);
      w = event_word(1'b1, s, e);
    end else if (pick < 90) begin
      w = read_word(($urandom_range(0, 3) != 0) ? $urandom_range(0, TARGET_POOL - 1)
                                                : $urandom_range(0, TARGET_COUNT - 1));
    end else begin
      case ($urandom_range(0, 3))
        0: w = event_word(1'b0, $urandom_range(0, 8191), $urandom_range(0, 8191));
        1: begin
          s = $urandom_range(0, 8191);
          w = event_word(1'b1, s, $urandom_range(0, s));
        end
        2: w = event_word(1'b1, $urandom_range(TABLE_DEPTH, 8191), $urandom_range(0, 8191));
        default: w = any_word(ACT_SPARE);
      endcase
    end
    return w;
  endfunction

  // Offer one word and hold it until the block takes it
  task automatic send_word(input syn_word_t w);
    int gap;
    gap = draw_gap(src_run, src_calm);
    if (gap > 0) begin
      evt.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    evt.valid         <= 1'b1;
    evt.action        <= w.action;
    evt.table_address <= w.table_address;
    evt.target_entry  <= w.target_entry;
    evt.fired         <= w.fired;
    evt.range_start   <= w.range_start;
    evt.range_stop    <= w.range_stop;
    evt.read_target   <= w.read_target;
    do @(posedge clk_i); while (!(evt.valid && evt.ready));
    board.note_word(w);
    words_sent++;
  endtask

  // End a phase with a read so all earlier walks are issued, then drain
  task automatic close_phase();
    send_word(read_word($urandom_range(0, TARGET_POOL - 1)));
    evt.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_weight(input logic [WEIGHT_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    board.weight_q = value;
    weights_written++;
  endtask

  // Result side: random stalls, one long hold-off to back up the input
  initial begin
    int gap;
    int hold_left;
    int results_seen;
    hold_left    = 0;
    results_seen = 0;
    res.ready    = 1'b1;
    forever begin
      @(posedge clk_i);
      if (res.valid && res.ready) begin
        board.check_tally(res.target_id, res.total);
        results_seen++;
        gap = (results_seen == PRESSURE_AT) ? PRESSURE_CYCLES : draw_gap(snk_run, snk_calm);
        if (gap > 0) begin
          res.ready <= 1'b0;
          hold_left = gap;
        end
      end else if (hold_left > 0) begin
        hold_left--;
        if (hold_left == 0) res.ready <= 1'b1;
      end
    end
  end

  // Stimulus
  initial begin
    logic [WEIGHT_W-1:0] phase_weight [5];
    evt.valid         = 1'b0;
    evt.action        = ACT_LOAD;
    evt.table_address = '0;
    evt.target_entry  = '0;
    evt.fired         = 1'b0;
    evt.range_start   = '0;
    evt.range_stop    = '0;
    evt.read_target   = '0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    rst_ni            = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_weight(WEIGHT_RST);

    // Table edges, quiet, empty, reversed and clamped ranges, spare action
    send_word(load_word(0, 0));
    send_word(load_word(TABLE_DEPTH - 1, TARGET_COUNT - 1));
    send_word(load_word(1, TARGET_COUNT - 1));
    send_word(load_word(2, 0));
    send_word(event_word(1'b1, 0, 3));
    send_word(event_word(1'b0, 0, 3));
    send_word(event_word(1'b1, 3, 3));
    send_word(event_word(1'b1, 2, 1));
    send_word(event_word(1'b1, TABLE_DEPTH - 1, 8191));
    send_word(event_word(1'b1, 8191, 8191));
    send_word(event_word(1'b1, TABLE_DEPTH, 8191));
    send_word(any_word(ACT_SPARE));
    send_word(read_word(0));
    send_word(read_word(TARGET_COUNT - 1));
    send_word(read_word(0));
    send_word(read_word(512));
    close_phase();

    // Drive one target into positive, then negative saturation
    write_weight(32'h7FFF_FFFF);
    for (int a = SAT_BASE; a < TABLE_DEPTH; a++) send_word(load_word(a, SAT_TARGET));
    for (int k = 0; k < SAT_EVENTS; k++)
      send_word(event_word(1'b1, SAT_BASE + $urandom_range(0, 3),
                           $urandom_range(TABLE_DEPTH, 8191)));
    send_word(read_word(SAT_TARGET));
    close_phase();
    write_weight(32'h8000_0000);
    for (int k = 0; k < SAT_EVENTS; k++)
      send_word(event_word(1'b1, SAT_BASE + $urandom_range(0, 3),
                           $urandom_range(TABLE_DEPTH, 8191)));
    send_word(read_word(SAT_TARGET));
    close_phase();

    // Random phases, one weight each
    phase_weight[0] = 32'h0000_0000;
    phase_weight[1] = 32'hFFFF_FFFF;
    phase_weight[2] = $urandom;
    phase_weight[3] = WEIGHT_RST;
    phase_weight[4] = $urandom;
    foreach (phase_weight[p]) begin
      write_weight(phase_weight[p]);
      for (int k = 0; k < RANDOM_PHASE_WORDS; k++) send_word(random_word());
      close_phase();
    end

    repeat (END_CYCLES) @(posedge clk_i);
    $display("Sent %0d words under %0d weight settings, checked %0d results.",
             words_sent, weights_written, board.checked);
    $display("Included table edges, clamped and empty ranges, saturation and a long stall.");
    if (board.errors == 0 && board.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #(LIMIT_NS);
    $display("Timeout with %0d results still pending", board.pending());
    $display("Some tests failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/essa_pkg.sv
rtl/core/essa_if.sv
rtl/core/essa_front.sv
rtl/core/essa_fifo.sv
rtl/core/essa_back.sv
rtl/core/event_sparse_synapse_accumulate.sv
tb/sv/event_sparse_synapse_accumulate_tb.sv
